### design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the scoped symbol table
// request and result transfer types, request codes, table entry layout
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 64;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_ENTER = 2'd0;
  localparam logic [1:0] REQ_LOOK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [KEY_W-1:0]          key;
    logic [LEVEL_W-1:0]        level;
    logic [TYPE_W-1:0]         type_in;
    logic signed [VALUE_W-1:0] value_in;
  } sst_req_t;

  typedef struct packed {
    logic                      found;
    logic [LEVEL_W-1:0]        level_out;
    logic [TYPE_W-1:0]         type_out;
    logic signed [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0]        cleared_count;
    logic                      table_full;
  } sst_rsp_t;

  // one slot of the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEVEL_W-1:0] level;
    logic [TYPE_W-1:0]  etype;
    logic [VALUE_W-1:0] value;
  } sst_entry_t;

  // running scan state handed to the compare unit
  typedef struct packed {
    logic               hit;
    logic               free;
    logic               found;
    logic [LEVEL_W-1:0] best_level;
  } sst_track_t;

  // decisions of the compare unit for the slot under test
  typedef struct packed {
    logic hit_take;
    logic free_take;
    logic look_take;
    logic clr_take;
  } sst_flags_t;

endpackage

### design/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: simple dual-port synchronous ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sst_match.sv
// ----------------------------------------------------------------------------
// sst_match: shared compare unit
// tests one slot against the pending request and the running scan state
// ----------------------------------------------------------------------------
module sst_match (
  input  sst_pkg::sst_req_t   req_i,
  input  logic                slot_valid_i,
  input  sst_pkg::sst_entry_t entry_i,
  input  sst_pkg::sst_track_t track_i,
  output sst_pkg::sst_flags_t flags_o
);
  import sst_pkg::*;

  logic key_eq;
  logic lvl_eq;
  logic lvl_ge;
  logic lvl_gt;

  assign key_eq = (entry_i.key == req_i.key);
  assign lvl_eq = (entry_i.level == req_i.level);
  assign lvl_ge = (entry_i.level >= req_i.level);
  assign lvl_gt = (entry_i.level > track_i.best_level);

  always_comb begin
    flags_o = '0;
    unique case (req_i.req_type)
      REQ_ENTER: begin
        flags_o.hit_take  = slot_valid_i && key_eq && lvl_eq && !track_i.hit;
        flags_o.free_take = !slot_valid_i && !track_i.free;
      end
      REQ_LOOK: begin
        flags_o.look_take = slot_valid_i && key_eq && (!track_i.found || lvl_gt);
      end
      REQ_CLEAR: begin
        flags_o.clr_take = slot_valid_i && lvl_ge;
      end
      default: begin
        flags_o = '0;
      end
    endcase
  end

endmodule

### design/scoped_symbol_table_core.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table_core: fixed-capacity block-structured symbol table
// enter, look up and scope clear over a table scanned one slot per cycle
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i / in_ready_o / in_data_i) takes one request per
//   transfer: enter, look up, or clear of every level at or above a level
//   out channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
//   result per request, in request order
//   each request walks every slot once through the shared compare unit,
//   reading one slot per cycle from the entry memory; an enter then has a
//   write state of its own in which it writes its slot
//   after the scan a request passes the drain state, the write state for
//   enter only, and the done state before out_valid_o rises; a new request
//   is taken only once the last one has left the done state
//   in_ready_o is high only while no request is in the scan; a finished
//   result waits in the output register and the next request may already be
//   taken, but that request cannot finish until the receiver takes the result
//   reset: valid marks live in a small memory that is swept clear slot by
//   slot after reset; in_ready_o stays low during that sweep
// ----------------------------------------------------------------------------
module scoped_symbol_table_core #(
  parameter int unsigned Entries = sst_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sst_pkg::sst_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sst_pkg::sst_rsp_t out_data_o
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(Entries);
  localparam logic [AW-1:0] LAST_ADDR = AW'(Entries - 1);

  // sequencer codes
  localparam logic [2:0] ST_INIT  = 3'd0; // valid mark sweep after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2; // issue one slot read per cycle
  localparam logic [2:0] ST_DRAIN = 3'd3; // test the last slot read
  localparam logic [2:0] ST_WRITE = 3'd4; // enter writes its slot
  localparam logic [2:0] ST_DONE  = 3'd5; // hand result to output register

  logic [2:0] state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] ridx_q;
  logic          rvld_q;

  sst_req_t req_q;

  // scan tracking
  logic          hit_q, free_q, found_q, full_q;
  logic [AW-1:0] hit_idx_q, free_idx_q;
  logic [LEVEL_W-1:0] best_level_q;
  logic [TYPE_W-1:0]  best_type_q;
  logic [VALUE_W-1:0] best_value_q;
  logic [COUNT_W-1:0] cnt_q;

  logic     out_valid_q;
  sst_rsp_t out_data_q;

  // memory ports
  logic          v_we, v_wdata, v_rdata;
  logic [AW-1:0] v_waddr;
  logic          e_we;
  logic [AW-1:0] e_waddr;
  sst_entry_t    e_wdata, e_rdata;
  logic          rd_en;

  sst_track_t track;
  sst_flags_t flags;
  logic       eval;
  logic       accept;
  logic       last;
  logic       out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign last     = (addr_q == LAST_ADDR);
  assign eval     = rvld_q;
  assign rd_en    = (state_q == ST_SCAN);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // valid marks
  sst_ram #(
    .Width (1),
    .Depth (Entries),
    .AddrW (AW)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (v_rdata)
  );

  // key, level, type and value per slot
  sst_ram #(
    .Width ($bits(sst_entry_t)),
    .Depth (Entries),
    .AddrW (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (e_rdata)
  );

  assign track.hit        = hit_q;
  assign track.free       = free_q;
  assign track.found      = found_q;
  assign track.best_level = best_level_q;

  sst_match u_match (
    .req_i        (req_q),
    .slot_valid_i (v_rdata),
    .entry_i      (e_rdata),
    .track_i      (track),
    .flags_o      (flags)
  );

  // memory write selection: sweep, clear on the fly, enter commit
  always_comb begin
    v_we    = 1'b0;
    v_waddr = ridx_q;
    v_wdata = 1'b0;
    e_we    = 1'b0;
    e_waddr = hit_idx_q;
    e_wdata.key   = req_q.key;
    e_wdata.level = req_q.level;
    e_wdata.etype = req_q.type_in;
    e_wdata.value = req_q.value_in;
    if (state_q == ST_INIT) begin
      v_we    = 1'b1;
      v_waddr = addr_q;
    end else if (eval && flags.clr_take) begin
      v_we = 1'b1;
    end else if (state_q == ST_WRITE) begin
      if (hit_q) begin
        e_we = 1'b1;
      end else if (free_q) begin
        e_we    = 1'b1;
        e_waddr = free_idx_q;
        v_we    = 1'b1;
        v_waddr = free_idx_q;
        v_wdata = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_INIT: begin
        if (last) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          addr_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = (req_q.req_type == REQ_ENTER) ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
        addr_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      addr_q      <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      rvld_q  <= rd_en;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, scan tracking and result registers
  always_ff @(posedge clk_i) begin
    ridx_q <= addr_q;
    if (accept) begin
      req_q        <= in_data_i;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      found_q      <= 1'b0;
      full_q       <= 1'b0;
      best_level_q <= '0;
      best_type_q  <= '0;
      best_value_q <= '0;
      cnt_q        <= '0;
    end else begin
      if (eval && flags.hit_take) begin
        hit_q     <= 1'b1;
        hit_idx_q <= ridx_q;
      end
      if (eval && flags.free_take) begin
        free_q     <= 1'b1;
        free_idx_q <= ridx_q;
      end
      if (eval && flags.look_take) begin
        found_q      <= 1'b1;
        best_level_q <= e_rdata.level;
        best_type_q  <= e_rdata.etype;
        best_value_q <= e_rdata.value;
      end
      // count saturates for tables above the count range
      if (eval && flags.clr_take && cnt_q != COUNT_MAX) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_WRITE && !hit_q && !free_q) begin
        full_q <= 1'b1;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q.found         <= found_q;
      out_data_q.level_out     <= best_level_q;
      out_data_q.type_out      <= best_type_q;
      out_data_q.value_out     <= best_value_q;
      out_data_q.cleared_count <= cnt_q;
      out_data_q.table_full    <= full_q;
    end
  end

endmodule

### design/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level assertions for the scoped symbol table
// attached to the top level by the bind statement below
// ----------------------------------------------------------------------------
module sst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sst_pkg::sst_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sst_pkg::sst_rsp_t out_data_o
);
  import sst_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one request at a time: the scan closes the input after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input open during scan");

  // a result carries at most one kind of answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.table_full) &&
                    !(out_data_o.found && out_data_o.cleared_count != '0) &&
                    !(out_data_o.table_full && out_data_o.cleared_count != '0))
    else $error("mixed result kinds");

  // a miss reports no entry contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.level_out == '0 && out_data_o.type_out == '0 &&
      out_data_o.value_out == '0)
    else $error("miss with entry contents");

endmodule

bind scoped_symbol_table_core sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### dv/scoped_symbol_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scoped_symbol_table_core_tb: self-checking bench of the scoped symbol table
// requests go in through a gapped driver and results come out through a
// stalling monitor; a shadow table predicts every result, which is compared
// field by field in order
// ----------------------------------------------------------------------------
module scoped_symbol_table_core_tb;
  import sst_pkg::*;

  localparam int unsigned TABLE_SLOTS = DEFAULT_ENTRIES;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned POOL_SIZE = 8;
  // the one request code with no meaning; the block must ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  sst_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sst_rsp_t out_data_o;

  scoped_symbol_table_core #(
    .Entries(TABLE_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // shadow table: same slot layout as the block, updated on each accepted
  // request transfer
  // --------------------------------------------------------------------------
  logic               sym_valid [TABLE_SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0]   sym_key   [TABLE_SLOTS];
  logic [LEVEL_W-1:0] sym_level [TABLE_SLOTS];
  logic [TYPE_W-1:0]  sym_type  [TABLE_SLOTS];
  logic [VALUE_W-1:0] sym_value [TABLE_SLOTS];

  sst_req_t pending_reqs[$];   // requests not yet handed to the driver
  sst_rsp_t expected_rsps[$];  // predicted results, oldest first

  int unsigned total_reqs;
  int unsigned accepted_reqs = 0;
  int unsigned checked_rsps = 0;
  int unsigned error_count = 0;

  // sender and receiver pacing
  int unsigned send_idle = 0;
  int unsigned send_burst = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_burst = 0;

  // stimulus generator state
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  logic [LEVEL_W-1:0] scope_depth = '0;

  // apply one request to the shadow table and return the result it causes
  function automatic sst_rsp_t apply_to_table(sst_req_t rq);
    sst_rsp_t           rsp;
    logic               hit;
    logic               have_free;
    int unsigned        slot;
    logic [COUNT_W-1:0] freed;
    rsp       = '0;
    hit       = 1'b0;
    have_free = 1'b0;
    slot      = 0;
    freed     = '0;
    case (rq.req_type)
      REQ_ENTER: begin
        // an existing key and level is updated in place, never fails
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (sym_valid[i]) begin
            if (!hit && sym_key[i] == rq.key && sym_level[i] == rq.level) begin
              sym_type[i]  = rq.type_in;
              sym_value[i] = rq.value_in;
              hit          = 1'b1;
            end
          end else if (!have_free) begin
            have_free = 1'b1;
            slot      = i;
          end
        end
        if (!hit) begin
          if (!have_free) begin
            rsp.table_full = 1'b1;
          end else begin
            sym_valid[slot] = 1'b1;
            sym_key[slot]   = rq.key;
            sym_level[slot] = rq.level;
            sym_type[slot]  = rq.type_in;
            sym_value[slot] = rq.value_in;
          end
        end
      end
      REQ_LOOK: begin
        // innermost scope wins; a tie keeps the lowest slot
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (sym_valid[i] && sym_key[i] == rq.key &&
              (!rsp.found || sym_level[i] > rsp.level_out)) begin
            rsp.found     = 1'b1;
            rsp.level_out = sym_level[i];
            rsp.type_out  = sym_type[i];
            rsp.value_out = sym_value[i];
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (sym_valid[i] && sym_level[i] >= rq.level) begin
            sym_valid[i] = 1'b0;
            if (freed != COUNT_MAX) freed++;
          end
        end
        rsp.cleared_count = freed;
      end
      default: begin
        // unused code: nothing changes, all fields zero
      end
    endcase
    return rsp;
  endfunction

  task automatic push_req(logic [1:0] code, logic [KEY_W-1:0] k, logic [LEVEL_W-1:0] lv,
                          logic [TYPE_W-1:0] ty, logic [VALUE_W-1:0] val);
    sst_req_t rq;
    rq.req_type = code;
    rq.key      = k;
    rq.level    = lv;
    rq.type_in  = ty;
    rq.value_in = val;
    pending_reqs.push_back(rq);
  endtask

  // fill the table past capacity, update an existing entry while full, then
  // empty it again
  task automatic gen_flood();
    logic [KEY_W-1:0]   first_key;
    logic [LEVEL_W-1:0] first_level;
    first_key   = KEY_W'($urandom);
    first_level = LEVEL_W'($urandom_range(0, 7));
    push_req(REQ_ENTER, first_key, first_level, TYPE_W'($urandom), $urandom);
    repeat (TABLE_SLOTS + $urandom_range(0, 3)) begin
      push_req(REQ_ENTER, KEY_W'($urandom), LEVEL_W'($urandom_range(0, 7)),
               TYPE_W'($urandom), $urandom);
    end
    push_req(REQ_ENTER, first_key, first_level, TYPE_W'($urandom), $urandom);
    push_req(REQ_LOOK, first_key, '0, '0, '0);
    push_req(REQ_CLEAR, '0, LEVEL_W'($urandom_range(1, 7)), '0, '0);
    push_req(REQ_CLEAR, '0, '0, '0, '0);
    scope_depth = '0;
  endtask

  // block-structured traffic: declarations in the current scope, look ups,
  // scope opens and closes, with some raw noise mixed in
  task automatic gen_scope_burst();
    int unsigned r;
    if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, POOL_SIZE-1)] = KEY_W'($urandom);
    repeat ($urandom_range(4, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        push_req(REQ_ENTER, key_pool[$urandom_range(0, POOL_SIZE-1)], scope_depth,
                 TYPE_W'($urandom), $urandom);
      end else if (r < 35) begin
        push_req(REQ_ENTER, key_pool[$urandom_range(0, POOL_SIZE-1)],
                 LEVEL_W'($urandom_range(0, 255)), TYPE_W'($urandom), $urandom);
      end else if (r < 65) begin
        push_req(REQ_LOOK, key_pool[$urandom_range(0, POOL_SIZE-1)],
                 LEVEL_W'($urandom), TYPE_W'($urandom), $urandom);
      end else if (r < 78) begin
        // open a scope; generates no transfer
        if (scope_depth != '1) scope_depth++;
      end else if (r < 90) begin
        // close the innermost scope
        push_req(REQ_CLEAR, KEY_W'($urandom), scope_depth, TYPE_W'($urandom), $urandom);
        if (scope_depth != '0) scope_depth--;
      end else begin
        push_req(2'($urandom_range(0, 3)), KEY_W'($urandom), LEVEL_W'($urandom),
                 TYPE_W'($urandom), $urandom);
      end
    end
  endtask

  // sender gap after a transfer: mostly none or short, a few long, and
  // stretches with no gaps at all
  function automatic int unsigned pick_send_gap();
    int unsigned r;
    if (send_burst != 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) send_burst = $urandom_range(10, 30);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: result %0d: %s", $time, checked_rsps, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // driver: presents the next pending request, predicts on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(apply_to_table(in_data_i));
        accepted_reqs++;
        send_idle = pick_send_gap();
        if (send_idle == 0 && pending_reqs.size() != 0) begin
          // back to back: valid stays high, only the payload moves
          in_data_i <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (send_idle != 0) begin
          send_idle--;
        end else if (pending_reqs.size() != 0) begin
          in_data_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result transfer and paces out_ready_i
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sst_rsp_t want;
    int unsigned r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          check_field("found", 32'(out_data_o.found), 32'(want.found));
          check_field("level_out", 32'(out_data_o.level_out), 32'(want.level_out));
          check_field("type_out", 32'(out_data_o.type_out), 32'(want.type_out));
          check_field("value_out", out_data_o.value_out, want.value_out);
          check_field("cleared_count", 32'(out_data_o.cleared_count),
                      32'(want.cleared_count));
          check_field("table_full", 32'(out_data_o.table_full), 32'(want.table_full));
        end
        checked_rsps++;
      end
      // ready pacing: short and long stalls, plus stretches with none
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (recv_burst != 0) begin
        recv_burst--;
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
        end else if (r < 62) begin
          recv_burst = $urandom_range(50, 300);
          out_ready_i <= 1'b1;
        end else if (r < 96) begin
          recv_stall = $urandom_range(0, 3);
          out_ready_i <= 1'b0;
        end else begin
          recv_stall = $urandom_range(20, 150);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    // directed: empty table, field extremes, shadowing across levels,
    // update in place, unused code, clears with and without hits
    push_req(REQ_LOOK,   16'h0000, 8'd0,   8'h00, 32'h0000_0000);  // miss on empty table
    push_req(REQ_CLEAR,  16'h0000, 8'd0,   8'h00, 32'h0000_0000);  // frees nothing
    push_req(REQ_ENTER,  16'h0000, 8'd0,   8'h00, 32'h8000_0000);
    push_req(REQ_ENTER,  16'hffff, 8'd255, 8'hff, 32'h7fff_ffff);
    push_req(REQ_LOOK,   16'h0000, 8'd0,   8'h00, 32'h0000_0000);
    push_req(REQ_LOOK,   16'hffff, 8'd0,   8'h00, 32'h0000_0000);
    push_req(REQ_ENTER,  16'h1234, 8'd1,   8'h11, 32'hffff_ffff);
    push_req(REQ_ENTER,  16'h1234, 8'd3,   8'h33, 32'h0000_0003);
    push_req(REQ_ENTER,  16'h1234, 8'd2,   8'h22, 32'h0000_0002);
    push_req(REQ_LOOK,   16'h1234, 8'd0,   8'h00, 32'h0000_0000);  // innermost is level 3
    push_req(REQ_ENTER,  16'h1234, 8'd3,   8'ha5, 32'h5a5a_5a5a);  // update in place
    push_req(REQ_LOOK,   16'h1234, 8'd0,   8'h00, 32'h0000_0000);
    push_req(REQ_UNUSED, 16'hffff, 8'd255, 8'hff, 32'hffff_ffff);
    push_req(REQ_LOOK,   16'h5555, 8'd0,   8'h00, 32'h0000_0000);  // miss with table in use
    push_req(REQ_CLEAR,  16'h0000, 8'd3,   8'h00, 32'h0000_0000);  // level 3 and 255 go
    push_req(REQ_LOOK,   16'h1234, 8'd0,   8'h00, 32'h0000_0000);  // falls back to level 2
    push_req(REQ_CLEAR,  16'h0000, 8'd255, 8'h00, 32'h0000_0000);
    push_req(REQ_CLEAR,  16'h0000, 8'd0,   8'h00, 32'h0000_0000);
    push_req(REQ_LOOK,   16'hffff, 8'd0,   8'h00, 32'h0000_0000);

    // random: start with a table overflow, then mostly scoped traffic
    gen_flood();
    while (pending_reqs.size() < RANDOM_ITEMS + 19) begin
      if ($urandom_range(0, 99) < 4) gen_flood();
      else gen_scope_burst();
    end
    total_reqs = pending_reqs.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_reqs != total_reqs) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    // room for a stray late result to show up
    repeat (2 * (TABLE_SLOTS + 4)) @(posedge clk_i);

    if (error_count == 0) begin
      $display("scoped_symbol_table_core_tb: PASS");
    end else begin
      $display("scoped_symbol_table_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #4ms;
    $display("scoped_symbol_table_core_tb: FAIL");
    $finish;
  end

endmodule
